[design/fec_missing_packet_tracker_assert.svh]
// ----------------------------------------------------------------------------
// fec_missing_packet_tracker_assert.svh
// Assertion macros shared by the tracker's checker.
// ----------------------------------------------------------------------------
`ifndef FEC_MISSING_PACKET_TRACKER_ASSERT_SVH
`define FEC_MISSING_PACKET_TRACKER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define FMPT_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define FMPT_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/fmpt_pkg.sv]
// ----------------------------------------------------------------------------
// fmpt_pkg
// Types, codes and the control store of the FEC missing packet tracker.
// ----------------------------------------------------------------------------
package fmpt_pkg;

  localparam int MAX_ASSOC_DEF = 32;

  localparam int SEQ_W      = 16;
  localparam int STEP_W     = 8;
  localparam int CNT_W      = 6;
  localparam int IDX_W      = 5;
  localparam int REQ_W      = 2;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // request codes
  localparam logic [REQ_W-1:0] REQ_MARK = 2'd0;
  localparam logic [REQ_W-1:0] REQ_NTH  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_FIND = 2'd2;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
  localparam logic [ST_W-1:0] ST_SAME  = 2'd2;
  localparam logic [ST_W-1:0] ST_ZSTEP = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ASSOC = 2'd2;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [CNT_W-1:0] position;
    logic             mark_value;
    logic [SEQ_W-1:0] media_seq;
  } req_t;

  typedef struct packed {
    logic [SEQ_W-1:0] seq_out;
    logic [IDX_W-1:0] index_out;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] count_out;
  } rsp_t;

  // microcode
  localparam int UA_W = 3;
  localparam int OP_W = 3;
  localparam int CN_W = 2;

  localparam logic [UA_W-1:0] UA_IDLE  = 3'd0;
  localparam logic [UA_W-1:0] UA_MARK  = 3'd1;  // dispatch: request code + 1
  localparam logic [UA_W-1:0] UA_QCHK  = 3'd2;
  localparam logic [UA_W-1:0] UA_ICHK  = 3'd3;
  localparam logic [UA_W-1:0] UA_BAD   = 3'd4;
  localparam logic [UA_W-1:0] UA_QSCAN = 3'd5;
  localparam logic [UA_W-1:0] UA_ISCAN = 3'd6;

  localparam logic [OP_W-1:0] OP_NOP   = 3'd0;
  localparam logic [OP_W-1:0] OP_MARK  = 3'd1;
  localparam logic [OP_W-1:0] OP_QINIT = 3'd2;
  localparam logic [OP_W-1:0] OP_QSTEP = 3'd3;
  localparam logic [OP_W-1:0] OP_IINIT = 3'd4;
  localparam logic [OP_W-1:0] OP_ISTEP = 3'd5;
  localparam logic [OP_W-1:0] OP_BAD   = 3'd6;

  localparam logic [CN_W-1:0] CND_NEXT = 2'd0;  // go to nxt
  localparam logic [CN_W-1:0] CND_END  = 2'd1;  // finish always
  localparam logic [CN_W-1:0] CND_DP   = 2'd2;  // finish on datapath flag, else nxt

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [CN_W-1:0] cnd;
    logic [UA_W-1:0] nxt;
  } uc_word_t;

  function automatic uc_word_t uc_rom(input logic [UA_W-1:0] addr);
    uc_word_t w;
    case (addr)
      UA_MARK:  w = '{op: OP_MARK,  cnd: CND_END, nxt: UA_IDLE};
      UA_QCHK:  w = '{op: OP_QINIT, cnd: CND_DP,  nxt: UA_QSCAN};
      UA_ICHK:  w = '{op: OP_IINIT, cnd: CND_DP,  nxt: UA_ISCAN};
      UA_BAD:   w = '{op: OP_BAD,   cnd: CND_END, nxt: UA_IDLE};
      UA_QSCAN: w = '{op: OP_QSTEP, cnd: CND_DP,  nxt: UA_QSCAN};
      UA_ISCAN: w = '{op: OP_ISTEP, cnd: CND_DP,  nxt: UA_ISCAN};
      default:  w = '{op: OP_NOP,   cnd: CND_NEXT, nxt: UA_IDLE};
    endcase
    return w;
  endfunction

endpackage

[design/fec_missing_packet_tracker.sv]
// ----------------------------------------------------------------------------
// fec_missing_packet_tracker
// Missing-media map for one FEC packet: mark, nth-missing query, index search.
// ----------------------------------------------------------------------------
// Steps: a mark, a bad request or a rejected request runs a single control word;
//   a query scans up to MAP_BITS map bits and an index search up to lim entries
//   (lim = assoc_count capped at MAP_BITS); one scan step per cycle.
// Throughput: one item in flight; the next start is taken in the done cycle.
// Reset: synchronous, clears map, count, sequencer, registers to defaults; no stall.
module fec_missing_packet_tracker #(
  parameter int MAX_ASSOC = fmpt_pkg::MAX_ASSOC_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  fmpt_pkg::req_t                      req,
  input  logic                                cfg_we,
  input  logic [fmpt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fmpt_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic                                done,
  output fmpt_pkg::rsp_t                      result
);

  // map is capped at 32 bits
  localparam int MAP_BITS = (MAX_ASSOC < 32) ? MAX_ASSOC : 32;
  localparam int JW       = (MAP_BITS > 1) ? $clog2(MAP_BITS) : 1;
  localparam logic [6:0]    MAP_BITS_V = 7'(MAP_BITS);
  localparam logic [JW-1:0] J_LAST     = JW'(MAP_BITS - 1);

  // configuration registers
  logic [fmpt_pkg::SEQ_W-1:0]  base_seq;
  logic [fmpt_pkg::STEP_W-1:0] seq_step;
  logic [fmpt_pkg::CNT_W-1:0]  assoc_count;

  // tracker state
  logic [MAP_BITS-1:0]        missing_map, missing_map_next;
  logic [fmpt_pkg::CNT_W-1:0] missing_count, missing_count_next;

  // sequencer
  logic [fmpt_pkg::UA_W-1:0] pc, pc_next;
  fmpt_pkg::uc_word_t        uc;

  // datapath
  fmpt_pkg::req_t             op_req;
  logic [JW-1:0]              j, j_next;
  logic [fmpt_pkg::CNT_W-1:0] seen, seen_next;
  logic [fmpt_pkg::SEQ_W-1:0] acc, acc_next;

  logic                       accept;
  logic                       dp_end;
  logic                       step_end;
  logic [fmpt_pkg::ST_W-1:0]  st;
  logic [fmpt_pkg::SEQ_W-1:0] seq_val;
  logic [fmpt_pkg::IDX_W-1:0] idx_val;
  logic [6:0]                 lim;
  logic [6:0]                 j_plus;
  logic                       pos_in_map;
  logic [MAP_BITS-1:0]        pos_bit;
  logic                       cur_bit;
  logic                       map_bit_j;
  logic [fmpt_pkg::SEQ_W-1:0] step_ext;

  assign busy   = (pc != fmpt_pkg::UA_IDLE);
  assign accept = start && !busy;
  assign uc     = fmpt_pkg::uc_rom(pc);

  // search limit: assoc_count capped at map size
  assign lim = ({1'b0, assoc_count} < MAP_BITS_V) ? {1'b0, assoc_count} : MAP_BITS_V;
  assign j_plus   = 7'(j) + 7'd1;
  assign step_ext = {{(fmpt_pkg::SEQ_W - fmpt_pkg::STEP_W){1'b0}}, seq_step};

  assign pos_in_map = ({1'b0, op_req.position} < MAP_BITS_V);
  assign pos_bit    = MAP_BITS'(1) << op_req.position;
  assign cur_bit    = |(missing_map & pos_bit);
  assign map_bit_j  = missing_map[j];

  // datapath, driven by the current control word
  always_comb begin
    dp_end             = 1'b0;
    st                 = fmpt_pkg::ST_RANGE;
    seq_val            = '0;
    idx_val            = '0;
    missing_map_next   = missing_map;
    missing_count_next = missing_count;
    j_next             = j;
    seen_next          = seen;
    acc_next           = acc;
    case (uc.op)
      fmpt_pkg::OP_MARK: begin
        dp_end = 1'b1;
        if (pos_in_map) begin
          if (cur_bit == op_req.mark_value) begin
            st = fmpt_pkg::ST_SAME;
          end else if (op_req.mark_value) begin
            missing_map_next   = missing_map | pos_bit;
            missing_count_next = missing_count + 6'd1;
            st                 = fmpt_pkg::ST_OK;
          end else begin
            missing_map_next   = missing_map & ~pos_bit;
            missing_count_next = missing_count - 6'd1;
            st                 = fmpt_pkg::ST_OK;
          end
        end
      end
      fmpt_pkg::OP_QINIT: begin
        if (op_req.position == '0 || op_req.position > missing_count) begin
          dp_end = 1'b1;
        end else begin
          j_next    = '0;
          seen_next = '0;
          acc_next  = base_seq;
        end
      end
      fmpt_pkg::OP_QSTEP: begin
        if (map_bit_j && (seen + 6'd1 == op_req.position)) begin
          dp_end  = 1'b1;
          st      = fmpt_pkg::ST_OK;
          seq_val = acc;
        end else if (j == J_LAST) begin
          dp_end = 1'b1;
        end else begin
          j_next    = j + JW'(1);
          seen_next = seen + {5'd0, map_bit_j};
          acc_next  = acc + step_ext;
        end
      end
      fmpt_pkg::OP_IINIT: begin
        if (seq_step == '0) begin
          dp_end = 1'b1;
          st     = fmpt_pkg::ST_ZSTEP;
        end else if (lim == '0) begin
          dp_end = 1'b1;
        end else begin
          j_next   = '0;
          acc_next = base_seq;
        end
      end
      fmpt_pkg::OP_ISTEP: begin
        if (acc == op_req.media_seq) begin
          dp_end  = 1'b1;
          st      = fmpt_pkg::ST_OK;
          idx_val = fmpt_pkg::IDX_W'(j);
        end else if (j_plus >= lim) begin
          dp_end = 1'b1;
        end else begin
          j_next   = j + JW'(1);
          acc_next = acc + step_ext;
        end
      end
      fmpt_pkg::OP_BAD: begin
        dp_end = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // sequencer: dispatch on request code, conditional jump back to idle
  always_comb begin
    step_end = 1'b0;
    case (uc.cnd)
      fmpt_pkg::CND_END: begin
        pc_next  = fmpt_pkg::UA_IDLE;
        step_end = 1'b1;
      end
      fmpt_pkg::CND_DP: begin
        pc_next  = dp_end ? fmpt_pkg::UA_IDLE : uc.nxt;
        step_end = dp_end;
      end
      default: begin
        pc_next = uc.nxt;
      end
    endcase
    if (accept) begin
      pc_next = {1'b0, req.req_type} + fmpt_pkg::UA_MARK;
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      base_seq      <= '0;
      seq_step      <= 8'd1;
      assoc_count   <= '0;
      missing_map   <= '0;
      missing_count <= '0;
      pc            <= fmpt_pkg::UA_IDLE;
      done          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          fmpt_pkg::CFG_BASE:  base_seq    <= cfg_data;
          fmpt_pkg::CFG_STEP:  seq_step    <= cfg_data[fmpt_pkg::STEP_W-1:0];
          fmpt_pkg::CFG_ASSOC: assoc_count <= cfg_data[fmpt_pkg::CNT_W-1:0];
          default: begin
          end
        endcase
      end
      missing_map   <= missing_map_next;
      missing_count <= missing_count_next;
      pc            <= pc_next;
      done          <= step_end;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_req <= req;
    end
    j    <= j_next;
    seen <= seen_next;
    acc  <= acc_next;
    if (step_end) begin
      result.seq_out   <= seq_val;
      result.index_out <= idx_val;
      result.status    <= st;
      result.count_out <= missing_count_next;
    end
  end

endmodule

[design/fmpt_checker.sv]
// ----------------------------------------------------------------------------
// fmpt_checker
// Port-level checks of the FEC missing packet tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "fec_missing_packet_tracker_assert.svh"

module fmpt_checker #(
  parameter int MAX_ASSOC = fmpt_pkg::MAX_ASSOC_DEF
) (
  input logic           clk,
  input logic           rst,
  input logic           start,
  input logic           busy,
  input logic           done,
  input fmpt_pkg::rsp_t result
);

  localparam int MAP_BITS = (MAX_ASSOC < 32) ? MAX_ASSOC : 32;

  // a start transfer makes the block busy
  `FMPT_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy, "start not taken")
  // result strobe coincides with return to idle
  `FMPT_ASSERT_SAME(a_done_idle, clk, rst, done, !busy, "busy during done")
  // no result without an item in work
  `FMPT_ASSERT_SAME(a_done_work, clk, rst, done, $past(busy), "result from nowhere")
  // failed requests carry zero seq and index
  `FMPT_ASSERT_SAME(a_fail_zero, clk, rst, done && result.status != fmpt_pkg::ST_OK, result.seq_out == '0 && result.index_out == '0, "stale payload on failure")
  // count never exceeds map size
  `FMPT_ASSERT_SAME(a_count_max, clk, rst, done, result.count_out <= 6'(MAP_BITS), "count overflow")

endmodule

bind fec_missing_packet_tracker fmpt_checker #(
  .MAX_ASSOC(MAX_ASSOC)
) u_fmpt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

[dv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FEC missing packet tracker. A mirror of the
// missing map, its count and the three registers predicts every response;
// each strobed result is compared field by field with the oldest prediction.
// A directed opening hits the range, unchanged, zero-step, not-found,
// unknown-request and wrap cases, then random bursts run under several
// register settings.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  // map width as the block sees it: MAX_ASSOC capped at one 32-bit word
  localparam int MAP_BITS = (fmpt_pkg::MAX_ASSOC_DEF < 32) ? fmpt_pkg::MAX_ASSOC_DEF : 32;
  // request code the block has no use for; must come back as out of range
  localparam logic [fmpt_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_CYCLES  = MAP_BITS + 8;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 172;
  localparam int REPORT_LIMIT  = 10;

  logic                            clk       = 1'b0;
  logic                            rst       = 1'b1;
  logic                            start     = 1'b0;
  logic                            cfg_we    = 1'b0;
  logic [fmpt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [fmpt_pkg::CFG_DATA_W-1:0] cfg_data  = '0;
  fmpt_pkg::req_t                  req       = '0;
  logic                            busy;
  logic                            done;
  fmpt_pkg::rsp_t                  result;

  // --------------------------------------------------------------------------
  // Mirror of the tracker: registers, missing map and count, plus the queue
  // of responses still owed by the block.
  // --------------------------------------------------------------------------
  class missing_map_mirror;
    logic [fmpt_pkg::SEQ_W-1:0]  base_q;
    logic [fmpt_pkg::STEP_W-1:0] step_q;
    logic [fmpt_pkg::CNT_W-1:0]  assoc_q;
    logic [MAP_BITS-1:0]         map_q;
    logic [fmpt_pkg::CNT_W-1:0]  count_q;
    fmpt_pkg::rsp_t              owed_rsp[$];
    int                          mismatches;
    int                          kind_seen[4];
    int                          status_seen[4];

    function new();
      base_q     = '0;
      step_q     = fmpt_pkg::STEP_W'(1);
      assoc_q    = '0;
      map_q      = '0;
      count_q    = '0;
      mismatches = 0;
      kind_seen   = '{default: 0};
      status_seen = '{default: 0};
    endfunction

    // registers keep only their own width of the write data
    function void set_register(logic [fmpt_pkg::CFG_IDX_W-1:0] idx,
                               logic [fmpt_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        fmpt_pkg::CFG_BASE:  base_q  = data[fmpt_pkg::SEQ_W-1:0];
        fmpt_pkg::CFG_STEP:  step_q  = data[fmpt_pkg::STEP_W-1:0];
        fmpt_pkg::CFG_ASSOC: assoc_q = data[fmpt_pkg::CNT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [fmpt_pkg::SEQ_W-1:0] seq_at(int j);
      return fmpt_pkg::SEQ_W'(32'(base_q) + 32'(step_q) * j);
    endfunction

    function int search_limit();
      return (int'(assoc_q) < MAP_BITS) ? int'(assoc_q) : MAP_BITS;
    endfunction

    // one request against the mirror; updates map and count for marks
    function fmpt_pkg::rsp_t apply_request(fmpt_pkg::req_t r);
      fmpt_pkg::rsp_t o;
      int             seen;
      bit             hit;
      o        = '0;
      o.status = fmpt_pkg::ST_RANGE;
      seen     = 0;
      hit      = 1'b0;
      case (r.req_type)
        fmpt_pkg::REQ_MARK: begin
          if (int'(r.position) < MAP_BITS) begin
            if (map_q[r.position] == r.mark_value) begin
              o.status = fmpt_pkg::ST_SAME;
            end else begin
              map_q[r.position] = r.mark_value;
              count_q = r.mark_value ? count_q + 1'b1 : count_q - 1'b1;
              o.status = fmpt_pkg::ST_OK;
            end
          end
        end
        fmpt_pkg::REQ_NTH: begin
          // rank counts set bits from bit 0 upward, 1-based
          if (r.position != 0 && r.position <= count_q) begin
            for (int j = 0; j < MAP_BITS; j++) begin
              if (!hit && map_q[j]) begin
                seen++;
                if (seen == int'(r.position)) begin
                  o.seq_out = seq_at(j);
                  o.status  = fmpt_pkg::ST_OK;
                  hit       = 1'b1;
                end
              end
            end
          end
        end
        fmpt_pkg::REQ_FIND: begin
          if (step_q == 0) begin
            o.status = fmpt_pkg::ST_ZSTEP;
          end else begin
            for (int j = 0; j < search_limit(); j++) begin
              if (!hit && seq_at(j) == r.media_seq) begin
                o.index_out = fmpt_pkg::IDX_W'(j);
                o.status    = fmpt_pkg::ST_OK;
                hit         = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      o.count_out = count_q;
      return o;
    endfunction

    function void note_request(fmpt_pkg::req_t r);
      kind_seen[r.req_type]++;
      owed_rsp.push_back(apply_request(r));
    endfunction

    function void check_response(fmpt_pkg::rsp_t got);
      fmpt_pkg::rsp_t want;
      if (owed_rsp.size() == 0) begin
        if (mismatches < REPORT_LIMIT)
          $display("[%0t] unexpected result strobe: seq=%h idx=%0d st=%0d cnt=%0d",
                   $realtime, got.seq_out, got.index_out, got.status, got.count_out);
        mismatches++;
        return;
      end
      want = owed_rsp.pop_front();
      status_seen[want.status]++;
      if (got.seq_out !== want.seq_out || got.index_out !== want.index_out ||
          got.status !== want.status || got.count_out !== want.count_out) begin
        if (mismatches < REPORT_LIMIT)
          $display({"[%0t] result mismatch: exp seq=%h idx=%0d st=%0d cnt=%0d,",
                    " got seq=%h idx=%0d st=%0d cnt=%0d"},
                   $realtime, want.seq_out, want.index_out, want.status, want.count_out,
                   got.seq_out, got.index_out, got.status, got.count_out);
        mismatches++;
      end
    endfunction

    function int pending();
      return owed_rsp.size();
    endfunction
  endclass

  missing_map_mirror tracker_mirror = new();
  int cycle_count   = 0;
  int set_weight    = 50;  // percent of random marks that set a bit
  int settings_used = 0;

  fec_missing_packet_tracker i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  always #6 clk = ~clk;

  // Watchdog: far above the slowest legal run (every item a full scan plus
  // the longest sender gap).
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped by the cycle watchdog, %0d results still owed",
               tracker_mirror.pending());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Result side: the strobe is sampled at the edge that ends its cycle. The
  // block cannot be held off, so there is nothing to stall here.
  always @(posedge clk) begin
    if (!rst && done) tracker_mirror.check_response(result);
  end

  function automatic fmpt_pkg::req_t compose_request(logic [fmpt_pkg::REQ_W-1:0] kind,
                                                     int pos, bit val, int seq);
    fmpt_pkg::req_t r;
    r.req_type   = kind;
    r.position   = fmpt_pkg::CNT_W'(pos);
    r.mark_value = val;
    r.media_seq  = fmpt_pkg::SEQ_W'(seq);
    return r;
  endfunction

  // Random request shaped by the mirror: marks mostly land inside the
  // associated range, ranks hug the current count, index searches mostly
  // ask for members of the series. Unused fields always carry noise.
  function automatic fmpt_pkg::req_t random_request();
    fmpt_pkg::req_t r;
    int             pick;
    int             span;
    r.req_type   = fmpt_pkg::REQ_W'($urandom);
    r.position   = fmpt_pkg::CNT_W'($urandom);
    r.mark_value = 1'($urandom);
    r.media_seq  = fmpt_pkg::SEQ_W'($urandom);
    pick = $urandom_range(0, 99);
    span = tracker_mirror.search_limit();
    if (span == 0) span = MAP_BITS;
    if (pick < 45) begin
      r.req_type   = fmpt_pkg::REQ_MARK;
      if ($urandom_range(0, 9) != 0)
        r.position = fmpt_pkg::CNT_W'($urandom_range(0, span - 1));
      r.mark_value = ($urandom_range(0, 99) < set_weight);
    end else if (pick < 70) begin
      r.req_type = fmpt_pkg::REQ_NTH;
      if ($urandom_range(0, 9) != 0)
        r.position = fmpt_pkg::CNT_W'($urandom_range(0, int'(tracker_mirror.count_q) + 1));
    end else if (pick < 94) begin
      r.req_type = fmpt_pkg::REQ_FIND;
      if ($urandom_range(0, 9) < 7)
        r.media_seq = tracker_mirror.seq_at($urandom_range(0, span + 1));
    end else begin
      r.req_type = REQ_UNUSED;
    end
    return r;
  endfunction

  // Present one request and hold it until the block takes it. start stays
  // high on return so a following request goes out back to back.
  task automatic issue(fmpt_pkg::req_t item);
    start <= 1'b1;
    req   <= item;
    do @(posedge clk); while (busy);
    tracker_mirror.note_request(item);
  endtask

  task automatic wait_drained();
    while (tracker_mirror.pending() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [fmpt_pkg::CFG_IDX_W-1:0] idx,
                                logic [fmpt_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker_mirror.set_register(idx, data);
  endtask

  // Reprogram all three registers once the block has gone quiet. Every
  // request yields a result, so an empty queue means the block is idle.
  // Bits above a register's width are sometimes filled to check they drop.
  task automatic configure(int base, int step, int assoc);
    logic [fmpt_pkg::CFG_DATA_W-1:0] upper;
    start <= 1'b0;
    wait_drained();
    upper = $urandom_range(0, 1) ? fmpt_pkg::CFG_DATA_W'($urandom) : '0;
    write_register(fmpt_pkg::CFG_BASE, fmpt_pkg::CFG_DATA_W'(base));
    write_register(fmpt_pkg::CFG_STEP,
                   {upper[fmpt_pkg::CFG_DATA_W-1:fmpt_pkg::STEP_W],
                    fmpt_pkg::STEP_W'(step)});
    write_register(fmpt_pkg::CFG_ASSOC,
                   {upper[fmpt_pkg::CFG_DATA_W-1:fmpt_pkg::CNT_W],
                    fmpt_pkg::CNT_W'(assoc)});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Directed opening: field extremes, each request kind and the corner
  // cases (range, unchanged mark, zero step, not found, wrap, code 3).
  task automatic directed_checks();
    configure(16'hFFF0, 3, 32);
    issue(compose_request(fmpt_pkg::REQ_MARK, 0, 1'b0, 16'hFFFF));   // already clear
    issue(compose_request(fmpt_pkg::REQ_MARK, 0, 1'b1, 0));
    issue(compose_request(fmpt_pkg::REQ_MARK, 31, 1'b1, 0));
    issue(compose_request(fmpt_pkg::REQ_MARK, 32, 1'b1, 0));         // past the map
    issue(compose_request(fmpt_pkg::REQ_MARK, 63, 1'b1, 16'hFFFF));
    issue(compose_request(fmpt_pkg::REQ_MARK, 31, 1'b1, 0));         // already set
    issue(compose_request(fmpt_pkg::REQ_NTH, 0, 1'b1, 16'hFFFF));    // rank zero
    issue(compose_request(fmpt_pkg::REQ_NTH, 1, 1'b0, 0));
    issue(compose_request(fmpt_pkg::REQ_NTH, 2, 1'b0, 0));           // wraps past 0xFFFF
    issue(compose_request(fmpt_pkg::REQ_NTH, 3, 1'b0, 0));           // above count
    issue(compose_request(fmpt_pkg::REQ_NTH, 63, 1'b1, 0));
    issue(compose_request(fmpt_pkg::REQ_FIND, 0, 1'b0, 16'hFFF0));
    issue(compose_request(fmpt_pkg::REQ_FIND, 63, 1'b1, tracker_mirror.seq_at(31)));
    // beyond limit
    issue(compose_request(fmpt_pkg::REQ_FIND, 0, 1'b0, tracker_mirror.seq_at(32)));
    issue(compose_request(fmpt_pkg::REQ_FIND, 0, 1'b0, 16'hFFF3));
    issue(compose_request(REQ_UNUSED, 63, 1'b1, 16'hFFFF));
    issue(compose_request(fmpt_pkg::REQ_MARK, 0, 1'b0, 0));
    issue(compose_request(fmpt_pkg::REQ_MARK, 31, 1'b0, 0));
    configure(0, 0, 63);
    issue(compose_request(fmpt_pkg::REQ_FIND, 0, 1'b0, 0));          // zero step
    issue(compose_request(fmpt_pkg::REQ_NTH, 1, 1'b0, 0));           // empty map
    configure(16'hFFFF, 255, 0);
    issue(compose_request(fmpt_pkg::REQ_FIND, 0, 1'b0, 16'hFFFF));   // nothing associated
    configure(16'hFFFF, 255, 63);
    issue(compose_request(fmpt_pkg::REQ_FIND, 0, 1'b0, tracker_mirror.seq_at(31)));
    issue(compose_request(fmpt_pkg::REQ_FIND, 0, 1'b0, tracker_mirror.seq_at(32)));
  endtask

  // Random bursts: random length, random gaps (short mostly, sometimes
  // longer than a full scan), and about a quarter of bursts run straight
  // into the next with start held high.
  task automatic run_bursts(int n_items);
    int left;
    int burst;
    int gap;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      repeat (burst) issue(random_request());
      left -= burst;
      gap = ($urandom_range(0, 3) == 0) ? 0 :
            $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    directed_checks();

    // register settings per phase; the first ones pin the extremes
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin configure(0, 1, 32); set_weight = 50; end
        1: begin configure(16'hFFFF, 255, 63); set_weight = 90; end
        2: begin
          configure($urandom_range(0, 65535), $urandom_range(1, 255), 32);
          set_weight = 10;
        end
        3: begin
          configure($urandom_range(0, 65535), 0, $urandom_range(0, 63));
          set_weight = 50;
        end
        4: begin configure($urandom_range(0, 65535), 1, 0); set_weight = 70; end
        default: begin
          configure($urandom_range(0, 65535),
                    ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 255),
                    $urandom_range(0, 63));
          set_weight = $urandom_range(0, 100);
        end
      endcase
      run_bursts(PHASE_ITEMS);
    end

    start <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display({"Covered %0d marks, %0d nth-missing queries, %0d index searches,",
              " %0d unused codes over %0d register settings"},
             tracker_mirror.kind_seen[fmpt_pkg::REQ_MARK],
             tracker_mirror.kind_seen[fmpt_pkg::REQ_NTH],
             tracker_mirror.kind_seen[fmpt_pkg::REQ_FIND],
             tracker_mirror.kind_seen[REQ_UNUSED],
             settings_used);
    $display({"Statuses: ok %0d, range/not found %0d, unchanged %0d, zero step %0d;",
              " %0d mismatches"},
             tracker_mirror.status_seen[fmpt_pkg::ST_OK],
             tracker_mirror.status_seen[fmpt_pkg::ST_RANGE],
             tracker_mirror.status_seen[fmpt_pkg::ST_SAME],
             tracker_mirror.status_seen[fmpt_pkg::ST_ZSTEP],
             tracker_mirror.mismatches);
    if (tracker_mirror.mismatches == 0 && tracker_mirror.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+design
design/fmpt_pkg.sv
design/fec_missing_packet_tracker.sv
design/fmpt_checker.sv
dv/tb.sv
